// ===== rtl/gbn_pkg.sv =====
// Shared types and constants for the go-back-N link endpoint.
// No dependencies; used by go_back_n_link_endpoint and the testbench.
`default_nettype none

package gbn_pkg;

  localparam int MAX_SEQ_DEF      = 7;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int SEQ_W            = 3;
  localparam int PAY_W            = 32;

  typedef enum logic [1:0] {
    CMD_PACKET    = 2'd0,
    CMD_FRAME     = 2'd1,
    CMD_CKSUM_ERR = 2'd2,
    CMD_TIMEOUT   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_DELIVER = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PKT,
    S_ACK,
    S_STAT,
    S_TOUT,
    S_TX
  } state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [PAY_W-1:0] packet_in;
    logic [SEQ_W-1:0] frame_seq;
    logic [SEQ_W-1:0] frame_ack;
    logic [PAY_W-1:0] frame_payload;
  } gbn_in_t;

  typedef struct packed {
    kind_e            out_kind;
    logic [SEQ_W-1:0] out_seq;
    logic [SEQ_W-1:0] out_ack;
    logic [PAY_W-1:0] out_payload;
    logic             last;
    logic             window_open;
    logic [SEQ_W-1:0] outstanding;
    logic             rejected;
  } gbn_out_t;

endpackage

`default_nettype wire

// ===== rtl/go_back_n_link_endpoint.sv =====
// Go-back-N sliding-window link endpoint: control FSM, window state, output register.
// Depends on gbn_pkg and gbn_store.
//
//  port group    direction  handshake                 word type
//  in_*          input      in_valid_i / in_ready_o   gbn_pkg::gbn_in_t
//  out_*         output     out_valid_o / out_ready_i gbn_pkg::gbn_out_t
//
// On a frame arrival the ack loop frees one slot a cycle; a timeout resends every
// outstanding frame, limited by the single read port of the store.
// Reset clears window pointers, counters and FSM; the packet store is not cleared.
// A full output register that is not being read stalls the emitting states;
// a new event is taken whenever the FSM is idle.
`default_nettype none

module go_back_n_link_endpoint #(
  parameter int MAX_SEQ      = gbn_pkg::MAX_SEQ_DEF,
  parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire gbn_pkg::gbn_in_t  in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output gbn_pkg::gbn_out_t      out_word_o
);

  localparam int SEQ_MOD = MAX_SEQ + 1;
  localparam int SW      = $clog2(SEQ_MOD);
  localparam int WW      = (SW > gbn_pkg::SEQ_W) ? SW : gbn_pkg::SEQ_W;
  localparam int PAY_W   = gbn_pkg::PAY_W;
  localparam int PW      = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
  localparam logic [SW-1:0] MAX_S   = SW'(MAX_SEQ);
  localparam logic [SW:0]   MOD_EXT = (SW + 1)'(SEQ_MOD);

  function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] s);
    return (s == MAX_S) ? '0 : s + 1'b1;
  endfunction

  // a <= b < c in cyclic order
  function automatic logic in_window(input logic [WW-1:0] a, input logic [WW-1:0] b,
                                     input logic [WW-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic logic [gbn_pkg::SEQ_W-1:0] to_field(input logic [SW-1:0] v);
    logic [WW-1:0] e;
    e = WW'(v);
    return e[gbn_pkg::SEQ_W-1:0];
  endfunction

  function automatic logic [PAY_W-1:0] pay_ext(input logic [PW-1:0] v);
    return PAY_W'(v);
  endfunction

  gbn_pkg::state_e   state_q, state_d;
  logic [SW-1:0]     nts_q, nts_d;       // next to send
  logic [SW-1:0]     oldest_q, oldest_d;
  logic [SW-1:0]     exp_q, exp_d;       // expected inbound sequence
  logic [SW-1:0]     count_q, count_d;
  logic [SW-1:0]     rem_q, rem_d;       // frames left in a retransmit burst
  logic              deliver_q, deliver_d;
  gbn_pkg::gbn_in_t  item_q, item_d;
  logic              out_valid_q, out_valid_d;
  gbn_pkg::gbn_out_t out_word_q, out_word_d;

  gbn_pkg::gbn_out_t res;
  logic              emit;
  logic              load_ok;
  logic              free_step;
  logic [SW-1:0]     count_inc;
  logic [SW-1:0]     ack_out;
  logic              wr_en;
  logic              rd_en;
  logic [SW-1:0]     rd_addr;
  logic [PW-1:0]     rd_data;

  gbn_store #(
    .DEPTH(SEQ_MOD),
    .AW   (SW),
    .DW   (PW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(nts_q),
    .wr_data_i(item_q.packet_in[PW-1:0]),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign load_ok   = !out_valid_q || out_ready_i;
  assign count_inc = count_q + 1'b1;
  assign ack_out   = (exp_q == '0) ? MAX_S : exp_q - 1'b1;
  assign free_step = (count_q != '0)
                     && in_window(WW'(oldest_q), WW'(item_q.frame_ack), WW'(nts_q));

  assign in_ready_o  = (state_q == gbn_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gbn_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (in_word_i.cmd)
            gbn_pkg::CMD_PACKET:  state_d = gbn_pkg::S_PKT;
            gbn_pkg::CMD_FRAME:   state_d = gbn_pkg::S_ACK;
            gbn_pkg::CMD_TIMEOUT: state_d = gbn_pkg::S_TOUT;
            default:              state_d = gbn_pkg::S_STAT;
          endcase
        end
      end
      gbn_pkg::S_PKT, gbn_pkg::S_STAT: begin
        if (load_ok) state_d = gbn_pkg::S_IDLE;
      end
      gbn_pkg::S_ACK: begin
        if (!free_step && load_ok) state_d = gbn_pkg::S_IDLE;
      end
      gbn_pkg::S_TOUT: begin
        if (count_q != '0) begin
          state_d = gbn_pkg::S_TX;
        end else if (load_ok) begin
          state_d = gbn_pkg::S_IDLE;
        end
      end
      gbn_pkg::S_TX: begin
        if (load_ok && (rem_q == SW'(1))) state_d = gbn_pkg::S_IDLE;
      end
      default: state_d = gbn_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    nts_d     = nts_q;
    oldest_d  = oldest_q;
    exp_d     = exp_q;
    count_d   = count_q;
    rem_d     = rem_q;
    deliver_d = deliver_q;
    item_d    = item_q;
    emit      = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = oldest_q;

    res             = '0;
    res.out_kind    = gbn_pkg::KIND_STATUS;
    res.last        = 1'b1;
    res.window_open = (count_q < MAX_S);
    res.outstanding = to_field(count_q);

    case (state_q)
      gbn_pkg::S_IDLE: begin
        if (in_valid_i) begin
          item_d    = in_word_i;
          deliver_d = (in_word_i.cmd == gbn_pkg::CMD_FRAME)
                      && (WW'(in_word_i.frame_seq) == WW'(exp_q));
          if (deliver_d) exp_d = seq_inc(exp_q);
        end
      end
      gbn_pkg::S_PKT: begin
        if (load_ok) begin
          emit = 1'b1;
          if (count_q >= MAX_S) begin
            res.rejected = 1'b1;
          end else begin
            wr_en           = 1'b1;
            count_d         = count_inc;
            nts_d           = seq_inc(nts_q);
            res.out_kind    = gbn_pkg::KIND_FRAME;
            res.out_seq     = to_field(nts_q);
            res.out_ack     = to_field(ack_out);
            res.out_payload = pay_ext(item_q.packet_in[PW-1:0]);
            res.window_open = (count_inc < MAX_S);
            res.outstanding = to_field(count_inc);
          end
        end
      end
      gbn_pkg::S_ACK: begin
        if (free_step) begin
          count_d  = count_q - 1'b1;
          oldest_d = seq_inc(oldest_q);
        end else if (load_ok) begin
          emit = 1'b1;
          if (deliver_q) begin
            res.out_kind    = gbn_pkg::KIND_DELIVER;
            res.out_payload = pay_ext(item_q.frame_payload[PW-1:0]);
          end
        end
      end
      gbn_pkg::S_STAT: begin
        emit = load_ok;
      end
      gbn_pkg::S_TOUT: begin
        if (count_q == '0) begin
          emit = load_ok;
        end else begin
          nts_d   = oldest_q;
          rem_d   = count_q;
          rd_en   = 1'b1;
          rd_addr = oldest_q;
        end
      end
      gbn_pkg::S_TX: begin
        if (load_ok) begin
          emit            = 1'b1;
          res.out_kind    = gbn_pkg::KIND_FRAME;
          res.out_seq     = to_field(nts_q);
          res.out_ack     = to_field(ack_out);
          res.out_payload = pay_ext(rd_data);
          res.last        = (rem_q == SW'(1));
          nts_d           = seq_inc(nts_q);
          rem_d           = rem_q - 1'b1;
          // read ahead so the next frame's data waits in the store's read register
          if (rem_q != SW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = seq_inc(nts_q);
          end
        end
      end
      default: begin
      end
    endcase

    out_word_d  = emit ? res : out_word_q;
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbn_pkg::S_IDLE;
      nts_q       <= '0;
      oldest_q    <= '0;
      exp_q       <= '0;
      count_q     <= '0;
      rem_q       <= '0;
      deliver_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nts_q       <= nts_d;
      oldest_q    <= oldest_d;
      exp_q       <= exp_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      deliver_q   <= deliver_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_word_q <= out_word_d;
  end

  // window consistency: next to send sits count slots past the oldest when idle
  logic [SW:0] win_sum;
  logic [SW:0] win_end;
  assign win_sum = (SW + 1)'(oldest_q) + (SW + 1)'(count_q);
  assign win_end = (win_sum >= MOD_EXT) ? win_sum - MOD_EXT : win_sum;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_S)
    else $error("outstanding count exceeds window");

  a_window_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbn_pkg::S_IDLE) |-> ((SW + 1)'(nts_q) == win_end))
    else $error("next-to-send out of step with oldest plus count");

  a_read_then_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> (state_q == gbn_pkg::S_TX))
    else $error("store read issued outside a retransmit burst");

  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res.rejected) |-> (res.last && (count_q >= MAX_S)))
    else $error("reject word with open window");

endmodule

`default_nettype wire

// ===== rtl/gbn_store.sv =====
// Packet buffer: one write port, one read port, registered read data.
// Standalone; instantiated by go_back_n_link_endpoint.
`default_nettype none

module gbn_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 32
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the go-back-N link endpoint: directed and random link events,
// with results predicted per event and compared word by word. Depends on gbn_pkg and
// go_back_n_link_endpoint.
`timescale 1ns / 100ps

module testbench;

  localparam int WINDOW      = gbn_pkg::MAX_SEQ_DEF;
  localparam int SEQ_W       = gbn_pkg::SEQ_W;
  localparam int PAY_W       = gbn_pkg::PAY_W;
  localparam int IDLE_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 250;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  gbn_pkg::gbn_in_t  in_word_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  gbn_pkg::gbn_out_t out_word_o;

  go_back_n_link_endpoint i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  // predicted endpoint state
  logic [SEQ_W-1:0] tx_next;
  logic [SEQ_W-1:0] tx_oldest;
  logic [SEQ_W-1:0] rx_expected;
  logic [SEQ_W-1:0] in_flight;
  logic [PAY_W-1:0] slot_data [WINDOW+1];

  gbn_pkg::gbn_out_t awaited_words [$];
  int       error_count  = 0;
  int       result_count = 0;
  int       idle_cycles  = 0;
  bit       quiet_sender = 1'b0;

  // receiver-side stall pattern
  int   ready_hold = 0;
  logic ready_next = 1'b0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  // a <= b < c, cyclically
  function automatic bit cyc_between(logic [SEQ_W-1:0] a, b, c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic gbn_pkg::gbn_out_t make_result(gbn_pkg::kind_e k,
                                                    logic [SEQ_W-1:0] seq,
                                                    logic [SEQ_W-1:0] ack,
                                                    logic [PAY_W-1:0] payload, logic rej);
    gbn_pkg::gbn_out_t r;
    r.out_kind    = k;
    r.out_seq     = seq;
    r.out_ack     = ack;
    r.out_payload = payload;
    r.last        = 1'b0;
    r.window_open = (in_flight < WINDOW);
    r.outstanding = in_flight;
    r.rejected    = rej;
    return r;
  endfunction

  function automatic gbn_pkg::gbn_out_t frame_of(logic [SEQ_W-1:0] seq);
    return make_result(gbn_pkg::KIND_FRAME, seq, rx_expected - 1'b1, slot_data[seq], 1'b0);
  endfunction

  task automatic predict_event(input gbn_pkg::gbn_in_t w);
    bit deliver;
    int n;
    case (w.cmd)
      gbn_pkg::CMD_PACKET: begin
        if (in_flight >= WINDOW) begin
          awaited_words.push_back(make_result(gbn_pkg::KIND_STATUS, '0, '0, '0, 1'b1));
        end else begin
          slot_data[tx_next] = w.packet_in;
          in_flight++;
          awaited_words.push_back(frame_of(tx_next));
          tx_next++;
        end
      end
      gbn_pkg::CMD_FRAME: begin
        deliver = (w.frame_seq == rx_expected);
        if (deliver) rx_expected++;
        while (in_flight > 0 && cyc_between(tx_oldest, w.frame_ack, tx_next)) begin
          in_flight--;
          tx_oldest++;
        end
        if (deliver)
          awaited_words.push_back(make_result(gbn_pkg::KIND_DELIVER, '0, '0,
                                              w.frame_payload, 1'b0));
        else
          awaited_words.push_back(make_result(gbn_pkg::KIND_STATUS, '0, '0, '0, 1'b0));
      end
      gbn_pkg::CMD_CKSUM_ERR: begin
        awaited_words.push_back(make_result(gbn_pkg::KIND_STATUS, '0, '0, '0, 1'b0));
      end
      default: begin
        // go back to the oldest unacked frame and resend everything outstanding
        tx_next = tx_oldest;
        n = int'(in_flight);
        for (int i = 0; i < n; i++) begin
          awaited_words.push_back(frame_of(tx_next));
          tx_next++;
        end
        if (n == 0)
          awaited_words.push_back(make_result(gbn_pkg::KIND_STATUS, '0, '0, '0, 1'b0));
      end
    endcase
    awaited_words[$].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (quiet_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic gbn_pkg::gbn_in_t make_event(gbn_pkg::cmd_e c, logic [PAY_W-1:0] pkt,
                                                  logic [SEQ_W-1:0] seq,
                                                  logic [SEQ_W-1:0] ack,
                                                  logic [PAY_W-1:0] pay);
    gbn_pkg::gbn_in_t w;
    w.cmd           = c;
    w.packet_in     = pkt;
    w.frame_seq     = seq;
    w.frame_ack     = ack;
    w.frame_payload = pay;
    return w;
  endfunction

  // Present one word, predict its results, return once it is accepted.
  task automatic send_event(input gbn_pkg::gbn_in_t w);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    predict_event(w);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_idle_endpoint();
    send_event(make_event(gbn_pkg::CMD_CKSUM_ERR, $urandom, 3'd7, 3'd7, $urandom));
    send_event(make_event(gbn_pkg::CMD_TIMEOUT, $urandom, 3'd0, 3'd0, $urandom));
    // out-of-order frame, ack with nothing outstanding
    send_event(make_event(gbn_pkg::CMD_FRAME, $urandom, 3'd5, 3'd7, $urandom));
  endtask

  task automatic test_window_fill();
    send_event(make_event(gbn_pkg::CMD_PACKET, 32'h0000_0000, '0, '0, '0));
    send_event(make_event(gbn_pkg::CMD_PACKET, 32'hFFFF_FFFF, '0, '0, '0));
    send_event(make_event(gbn_pkg::CMD_PACKET, 32'h5555_5555, '0, '0, '0));
    send_event(make_event(gbn_pkg::CMD_PACKET, 32'hAAAA_AAAA, '0, '0, '0));
    repeat (3) send_event(make_event(gbn_pkg::CMD_PACKET, $urandom, '0, '0, '0));
    // window full: refused
    send_event(make_event(gbn_pkg::CMD_PACKET, 32'hFFFF_FFFF, 3'd7, 3'd7, 32'hFFFF_FFFF));
    send_event(make_event(gbn_pkg::CMD_CKSUM_ERR, '0, '0, '0, '0));
  endtask

  task automatic test_resend_all();
    send_event(make_event(gbn_pkg::CMD_TIMEOUT, '0, '0, '0, '0));
  endtask

  task automatic test_ack_handling();
    // in order, ack equals next to send: outside the window, frees nothing
    send_event(make_event(gbn_pkg::CMD_FRAME, '0, 3'd0, 3'd7, 32'hFFFF_FFFF));
    // out of order, partial ack
    send_event(make_event(gbn_pkg::CMD_FRAME, '0, 3'd3, 3'd2, $urandom));
    send_event(make_event(gbn_pkg::CMD_FRAME, '0, 3'd1, 3'd6, 32'h0000_0000));
    send_event(make_event(gbn_pkg::CMD_TIMEOUT, '0, '0, '0, '0));
  endtask

  task automatic test_seq_wrap();
    repeat (3) send_event(make_event(gbn_pkg::CMD_PACKET, $urandom, '0, '0, '0));
    // ack wraps 7 -> 0
    send_event(make_event(gbn_pkg::CMD_FRAME, '0, 3'd2, 3'd0, $urandom));
    send_event(make_event(gbn_pkg::CMD_TIMEOUT, '0, '0, '0, '0));
  endtask

  task automatic test_random_traffic(input int count);
    gbn_pkg::gbn_in_t w;
    int r;
    for (int i = 0; i < count; i++) begin
      quiet_sender = (i >= 60 && i < 100);
      if (i == count / 2) wait_drained();
      w = make_event(gbn_pkg::CMD_CKSUM_ERR, $urandom, SEQ_W'($urandom_range(0, 7)),
                     SEQ_W'($urandom_range(0, 7)), $urandom);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        w.cmd = gbn_pkg::CMD_PACKET;
      end else if (r < 75) begin
        w.cmd = gbn_pkg::CMD_FRAME;
        if ($urandom_range(0, 99) < 70) w.frame_seq = rx_expected;
        // mostly acks that land inside the outstanding range
        if (in_flight > 0 && $urandom_range(0, 99) < 75)
          w.frame_ack = tx_oldest + SEQ_W'($urandom_range(0, in_flight - 1));
      end else if (r < 85) begin
        w.cmd = gbn_pkg::CMD_CKSUM_ERR;
      end else begin
        w.cmd = gbn_pkg::CMD_TIMEOUT;
      end
      send_event(w);
    end
    quiet_sender = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking, receiver stalls, watchdog
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] result %0d: %s got %0h expected %0h", $realtime, result_count, what,
             got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    gbn_pkg::gbn_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_words.size() == 0) begin
        report_mismatch("unexpected word", out_word_o, 0);
      end else begin
        want = awaited_words.pop_front();
        if (out_word_o.out_kind !== want.out_kind)
          report_mismatch("out_kind", out_word_o.out_kind, want.out_kind);
        if (out_word_o.out_seq !== want.out_seq)
          report_mismatch("out_seq", out_word_o.out_seq, want.out_seq);
        if (out_word_o.out_ack !== want.out_ack)
          report_mismatch("out_ack", out_word_o.out_ack, want.out_ack);
        if (out_word_o.out_payload !== want.out_payload)
          report_mismatch("out_payload", out_word_o.out_payload, want.out_payload);
        if (out_word_o.last !== want.last)
          report_mismatch("last", out_word_o.last, want.last);
        if (out_word_o.window_open !== want.window_open)
          report_mismatch("window_open", out_word_o.window_open, want.window_open);
        if (out_word_o.outstanding !== want.outstanding)
          report_mismatch("outstanding", out_word_o.outstanding, want.outstanding);
        if (out_word_o.rejected !== want.rejected)
          report_mismatch("rejected", out_word_o.rejected, want.rejected);
      end
      result_count++;
    end
  end

  // short stalls, occasional long ones, and long stretches always ready
  always @(negedge clk_i) begin
    if (ready_hold == 0) begin
      if (ready_next) begin
        ready_next = 1'b0;
        ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
      end else begin
        ready_next = 1'b1;
        ready_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 6);
      end
    end
    ready_hold--;
    out_ready_i <= ready_next;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] watchdog: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int settle;
    tx_next     = '0;
    tx_oldest   = '0;
    rx_expected = '0;
    in_flight   = '0;
    foreach (slot_data[i]) slot_data[i] = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_endpoint();
    test_window_fill();
    test_resend_all();
    test_ack_handling();
    test_seq_wrap();
    test_random_traffic(RANDOM_ITEMS);

    wait_drained();
    settle = 0;
    while (settle < 16) begin
      @(posedge clk_i);
      settle++;
    end

    if (error_count == 0 && awaited_words.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gbn_pkg.sv
rtl/gbn_store.sv
rtl/go_back_n_link_endpoint.sv
tb/sv/testbench.sv
